// ===== rtl/core/y86f_pkg.sv =====
// ----------------------------------------------------------------------------
// y86f_pkg
// Shared types, constants and opcode decode functions for the Y86 fetch stage.
// ----------------------------------------------------------------------------
package y86f_pkg;

  localparam int MEM_BYTES   = 4096;
  localparam int STORE_AW    = $clog2(MEM_BYTES);
  localparam int BANK_W      = 3;
  localparam int NUM_BANKS   = 1 << BANK_W;
  localparam int ROW_W       = STORE_AW - BANK_W;
  localparam int BANK_ROWS   = MEM_BYTES / NUM_BANKS;
  localparam int FETCH_BYTES = 6;

  typedef logic [7:0] byte_t;
  typedef logic [3:0] code_t;
  typedef logic [31:0] word_t;
  typedef logic [NUM_BANKS-1:0][7:0] bank_data_t;

  localparam code_t OP_HALT   = 4'h0;
  localparam code_t OP_NOP    = 4'h1;
  localparam code_t OP_RRMOVL = 4'h2;
  localparam code_t OP_IRMOVL = 4'h3;
  localparam code_t OP_RMMOVL = 4'h4;
  localparam code_t OP_MRMOVL = 4'h5;
  localparam code_t OP_OPL    = 4'h6;
  localparam code_t OP_JXX    = 4'h7;
  localparam code_t OP_CALL   = 4'h8;
  localparam code_t OP_RET    = 4'h9;
  localparam code_t OP_PUSHL  = 4'hA;
  localparam code_t OP_POPL   = 4'hB;
  localparam code_t OP_DUMP   = 4'hC;

  localparam code_t REG_NONE = 4'hF;

  localparam logic [1:0] STAT_AOK = 2'd0;
  localparam logic [1:0] STAT_ADR = 2'd1;
  localparam logic [1:0] STAT_INS = 2'd2;
  localparam logic [1:0] STAT_HLT = 2'd3;

  localparam logic [1:0] ACT_HOLD   = 2'd0;
  localparam logic [1:0] ACT_LOAD   = 2'd1;
  localparam logic [1:0] ACT_BUBBLE = 2'd2;

  typedef struct packed {
    logic [1:0] stat;
    code_t      icode;
    code_t      ifun;
    code_t      ra;
    code_t      rb;
    word_t      valc;
    word_t      valp;
  } fetch_t;

  function automatic logic op_valid(input code_t op);
    logic r;
    unique case (op) inside
      OP_HALT, OP_NOP, OP_RRMOVL, OP_IRMOVL, OP_RMMOVL, OP_MRMOVL, OP_OPL,
      OP_JXX, OP_CALL, OP_RET, OP_PUSHL, OP_POPL, OP_DUMP: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic op_has_regs(input code_t op);
    logic r;
    unique case (op) inside
      OP_RRMOVL, OP_IRMOVL, OP_RMMOVL, OP_MRMOVL, OP_OPL, OP_PUSHL, OP_POPL: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic op_has_const(input code_t op);
    logic r;
    unique case (op) inside
      OP_IRMOVL, OP_RMMOVL, OP_MRMOVL, OP_JXX, OP_CALL, OP_DUMP: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] op_length(input code_t op);
    logic [2:0] r;
    unique case (op) inside
      OP_RRMOVL, OP_OPL, OP_PUSHL, OP_POPL: r = 3'd2;
      OP_JXX, OP_CALL, OP_DUMP:             r = 3'd5;
      OP_IRMOVL, OP_RMMOVL, OP_MRMOVL:      r = 3'd6;
      default:                              r = 3'd1;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/y86f_store.sv =====
// ----------------------------------------------------------------------------
// y86f_store
// Instruction store split into byte-interleaved banks, so that six
// consecutive bytes starting at any address are read in a single access.
// ----------------------------------------------------------------------------
module y86f_store (
  input  logic                            clk,
  input  logic                            wr_en,
  input  logic [y86f_pkg::STORE_AW-1:0]   wr_addr,
  input  y86f_pkg::byte_t                 wr_data,
  input  logic                            rd_en,
  input  logic [y86f_pkg::STORE_AW-1:0]   rd_addr,
  output y86f_pkg::bank_data_t            rd_data
);
  import y86f_pkg::*;

  for (genvar j = 0; j < NUM_BANKS; j++) begin : g_bank
    byte_t               mem [BANK_ROWS];
    logic [BANK_W-1:0]   ofs;
    logic [STORE_AW-1:0] addr;

    // Each bank serves the one byte of the fetch window whose low bits match it.
    assign ofs  = BANK_W'(j) - rd_addr[BANK_W-1:0];
    assign addr = rd_addr + STORE_AW'(ofs);

    always_ff @(posedge clk) begin
      if (wr_en && (wr_addr[BANK_W-1:0] == BANK_W'(j))) begin
        mem[wr_addr[STORE_AW-1:BANK_W]] <= wr_data;
      end
      if (rd_en) begin
        rd_data[j] <= mem[addr[STORE_AW-1:BANK_W]];
      end
    end
  end

endmodule

// ===== rtl/core/y86f_decode.sv =====
// ----------------------------------------------------------------------------
// y86f_decode
// Aligns the fetched bytes, checks addresses and decodes the instruction
// fields, status and sequential next PC.
// ----------------------------------------------------------------------------
module y86f_decode (
  input  y86f_pkg::word_t      pc,
  input  y86f_pkg::bank_data_t bank_q,
  output y86f_pkg::fetch_t     fetch
);
  import y86f_pkg::*;

  byte_t                  b   [FETCH_BYTES];
  logic [FETCH_BYTES-1:0] ok;
  code_t                  op;
  code_t                  fn;
  logic                   valid_op;
  logic                   use_regs;
  logic                   use_const;
  logic                   const_ok;
  word_t                  const_raw;

  always_comb begin
    for (int k = 0; k < FETCH_BYTES; k++) begin
      b[k]  = bank_q[BANK_W'(pc[BANK_W-1:0] + BANK_W'(k))];
      ok[k] = (pc + 32'(k)) < 32'(MEM_BYTES);
    end
  end

  always_comb begin
    op        = ok[0] ? b[0][7:4] : OP_NOP;
    fn        = ok[0] ? b[0][3:0] : 4'h0;
    valid_op  = op_valid(op);
    use_regs  = op_has_regs(op);
    use_const = op_has_const(op);

    if (use_regs) begin
      const_ok  = ok[2] && ok[3] && ok[4] && ok[5];
      const_raw = {b[5], b[4], b[3], b[2]};
    end else begin
      const_ok  = ok[1] && ok[2] && ok[3] && ok[4];
      const_raw = {b[4], b[3], b[2], b[1]};
    end

    fetch.icode = op;
    fetch.ifun  = fn;
    fetch.ra    = (use_regs && ok[1]) ? b[1][7:4] : REG_NONE;
    fetch.rb    = (use_regs && ok[1]) ? b[1][3:0] : REG_NONE;
    fetch.valc  = (use_const && const_ok) ? const_raw : '0;
    fetch.valp  = pc + 32'(op_length(op));

    if (!ok[0]) begin
      fetch.stat = STAT_ADR;
    end else if (!valid_op) begin
      fetch.stat = STAT_INS;
    end else if ((use_regs && !ok[1]) || (use_const && !const_ok)) begin
      fetch.stat = STAT_ADR;
    end else if (op == OP_HALT) begin
      fetch.stat = STAT_HLT;
    end else begin
      fetch.stat = STAT_AOK;
    end
  end

endmodule

// ===== rtl/core/y86_pipeline_fetch_stage_top.sv =====
// ----------------------------------------------------------------------------
// y86_pipeline_fetch_stage_top
// Fetch stage of a 32-bit Y86 pipeline with a byte-wide instruction store.
// ----------------------------------------------------------------------------
// The block takes one word per cycle unless a full output stalls it; the fetch
// result of a cycle word is presented via the stage-one and output registers;
// load words write one store byte and return nothing. At acceptance the fetch
// PC is selected and six bytes are read from eight byte-interleaved store banks;
// the next cycle decodes them and forms the predicted PC, forwarded straight to
// the following word's PC selection, so cycle words may follow one another every
// cycle. An output register holds a finished result while new words are taken.
module y86_pipeline_fetch_stage_top (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  mode,
  input  logic [11:0]           mem_addr,
  input  logic [7:0]            mem_byte,
  input  logic [3:0]            d_stage_icode,
  input  logic [3:0]            e_stage_icode,
  input  logic                  e_branch_taken,
  input  logic [3:0]            m_stage_icode,
  input  logic                  m_branch_taken,
  input  logic [31:0]           m_fallthrough_pc,
  input  logic [3:0]            w_stage_icode,
  input  logic [31:0]           w_loaded_value,
  input  logic [11:0]           register_ids,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            d_action,
  output logic [31:0]           fetch_pc,
  output logic [1:0]            status,
  output logic [3:0]            icode,
  output logic [3:0]            ifun,
  output logic [3:0]            reg_a,
  output logic [3:0]            reg_b,
  output logic [31:0]           const_word,
  output logic [31:0]           next_seq_pc
);
  import y86f_pkg::*;

  word_t      pred_pc;
  logic       s1_valid;
  word_t      s1_pc;
  logic [1:0] s1_act;
  logic       s1_stall_f;

  logic       s1_adv;
  logic       accept;
  logic       cycle_acc;
  logic       load_acc;
  word_t      pred_cur;
  word_t      pred_next;
  word_t      pc_sel;
  logic       load_use;
  logic       ret_pending;
  logic       stall_f;
  logic       bubble_d;
  logic [1:0] act;
  bank_data_t bank_q;
  fetch_t     fetch;

  assign s1_adv    = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || s1_adv;
  assign accept    = in_valid && in_ready;
  assign cycle_acc = accept && mode;
  assign load_acc  = accept && !mode && (32'(mem_addr) < 32'(MEM_BYTES));

  assign pred_cur = s1_valid ? pred_next : pred_pc;

  always_comb begin
    if ((m_stage_icode == OP_JXX) && !m_branch_taken) begin
      pc_sel = m_fallthrough_pc;
    end else if (w_stage_icode == OP_RET) begin
      pc_sel = w_loaded_value;
    end else begin
      pc_sel = pred_cur;
    end

    load_use = ((e_stage_icode == OP_MRMOVL) || (e_stage_icode == OP_POPL)) &&
               ((register_ids[11:8] == register_ids[7:4]) ||
                (register_ids[11:8] == register_ids[3:0]));
    ret_pending = (d_stage_icode == OP_RET) || (e_stage_icode == OP_RET) ||
                  (m_stage_icode == OP_RET);
    stall_f  = load_use || ret_pending;
    bubble_d = ((e_stage_icode == OP_JXX) && !e_branch_taken) ||
               (!load_use && ret_pending);

    if (bubble_d) begin
      act = ACT_BUBBLE;
    end else if (!load_use) begin
      act = ACT_LOAD;
    end else begin
      act = ACT_HOLD;
    end
  end

  y86f_store u_store (
    .clk     (clk),
    .wr_en   (load_acc),
    .wr_addr (STORE_AW'(mem_addr)),
    .wr_data (mem_byte),
    .rd_en   (cycle_acc),
    .rd_addr (pc_sel[STORE_AW-1:0]),
    .rd_data (bank_q)
  );

  y86f_decode u_decode (
    .pc     (s1_pc),
    .bank_q (bank_q),
    .fetch  (fetch)
  );

  always_comb begin
    if (s1_stall_f) begin
      pred_next = s1_pc;
    end else if ((fetch.icode == OP_JXX) || (fetch.icode == OP_CALL)) begin
      pred_next = fetch.valc;
    end else begin
      pred_next = fetch.valp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pred_pc   <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_adv) begin
        pred_pc <= pred_next;
      end
      if (in_ready) begin
        s1_valid <= cycle_acc;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cycle_acc) begin
      s1_pc      <= pc_sel;
      s1_act     <= act;
      s1_stall_f <= stall_f;
    end
    if (s1_adv) begin
      d_action    <= s1_act;
      fetch_pc    <= s1_pc;
      status      <= fetch.stat;
      icode       <= fetch.icode;
      ifun        <= fetch.ifun;
      reg_a       <= fetch.ra;
      reg_b       <= fetch.rb;
      const_word  <= fetch.valc;
      next_seq_pc <= fetch.valp;
    end
  end

endmodule
